### src/utl_pkg.sv
// Package for the UTF-8 / Latin-1 transcoder: item types, mode codes
// and byte constants. No dependencies.
package utl_pkg;

  typedef enum logic [1:0] {
    MODE_IDENT    = 2'd0,
    MODE_L1_TO_U8 = 2'd1,
    MODE_U8_TO_L1 = 2'd2,
    MODE_RSVD     = 2'd3
  } utl_mode_e;

  localparam logic [7:0] ByteHiBit   = 8'h80;
  localparam logic [7:0] ByteLatinLo = 8'ha0;
  localparam logic [7:0] ByteLead2   = 8'hc0;
  localparam logic [7:0] ByteLeadC2  = 8'hc2;
  localparam logic [7:0] ByteLeadC3  = 8'hc3;
  localparam logic [7:0] ContMask    = 8'h3f;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } utl_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       status;
    logic       buffer_end;
    logic       last_of_run;
  } utl_out_t;

  typedef struct packed {
    logic lead_pending;
    logic lead_is_c3;
    logic halted;
  } utl_state_t;

  // Decode result for one item: up to two result items and the new state
  typedef struct packed {
    logic [1:0] cnt;
    utl_out_t   res0;
    utl_out_t   res1;
    utl_state_t state;
  } utl_dec_t;

endpackage

### src/utl_decode.sv
// Combinational decode of one input byte against the held state and mode.
// Depends on utl_pkg.
module utl_decode import utl_pkg::*; (
  input  utl_in_t    item_i,
  input  utl_state_t state_i,
  input  utl_mode_e  mode_i,
  output utl_dec_t   dec_o
);

  logic [7:0] b;
  logic       eob;
  logic       cont_bad;
  logic       err;
  utl_out_t   data0;
  utl_out_t   data1;
  utl_out_t   err_res;

  assign b   = item_i.in_byte;
  assign eob = item_i.end_of_buffer;

  // A continuation must be 10xxxxxx; after C2 it must also decode to 0xA0 or above
  assign cont_bad = ((b & ByteLead2) != ByteHiBit) ||
                    (!state_i.lead_is_c3 && !b[5]);

  assign err_res = '{out_byte: 8'h00, has_byte: 1'b0, status: 1'b1,
                     buffer_end: eob, last_of_run: 1'b1};

  // Classify the item and build its results
  always_comb begin
    dec_o       = '0;
    dec_o.state = state_i;
    err         = 1'b0;
    data0       = '{out_byte: b, has_byte: 1'b1, status: 1'b0,
                    buffer_end: 1'b0, last_of_run: 1'b0};
    data1       = data0;

    if (state_i.halted) begin
      // Drop until end of buffer, then report once
      if (eob) begin
        dec_o.cnt  = 2'd1;
        dec_o.res0 = err_res;
      end
    end else if (state_i.lead_pending) begin
      if (cont_bad) begin
        err = 1'b1;
      end else begin
        data0.out_byte = {1'b0, state_i.lead_is_c3, b[5:0]} | ByteHiBit;
        dec_o.cnt      = 2'd1;
        dec_o.state.lead_pending = 1'b0;
      end
    end else if (mode_i == MODE_IDENT || !b[7]) begin
      dec_o.cnt = 2'd1;
    end else begin
      case (mode_i)
        MODE_L1_TO_U8: begin
          if (b < ByteLatinLo) begin
            err = 1'b1;
          end else begin
            data0.out_byte = ByteLead2 | {6'd0, b[7:6]};
            data1.out_byte = ByteHiBit | (b & ContMask);
            dec_o.cnt      = 2'd2;
          end
        end
        MODE_U8_TO_L1: begin
          if ((b != ByteLeadC2 && b != ByteLeadC3) || eob) begin
            err = 1'b1;
          end else begin
            dec_o.state.lead_pending = 1'b1;
            dec_o.state.lead_is_c3   = (b == ByteLeadC3);
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end

    // Mark the final result of the run
    if (!state_i.halted && !err) begin
      if (dec_o.cnt == 2'd2) begin
        data1.buffer_end  = eob;
        data1.last_of_run = 1'b1;
      end else begin
        data0.buffer_end  = eob;
        data0.last_of_run = 1'b1;
      end
      dec_o.res0 = data0;
      dec_o.res1 = data1;
    end

    // Error: one status result, halt unless at end of buffer
    if (err) begin
      dec_o.cnt                = 2'd1;
      dec_o.res0               = err_res;
      dec_o.state.lead_pending = 1'b0;
      dec_o.state.halted       = !eob;
    end

    // End of buffer clears the held lead and the halt
    if (eob) begin
      dec_o.state.lead_pending = 1'b0;
      dec_o.state.halted       = 1'b0;
    end
  end

endmodule

### src/utf8_latin1_transcoder_top.sv
// Results pass through the input register, then the result register; the
// result register loads only when the output can take it. Throughput: one item
// per cycle while out_stall_i is low; a Latin-1 byte expanded to two UTF-8 bytes
// holds the input, since the result port carries one byte at a time.
// Reset (rst_ni low, asynchronous): mode identity, no lead held, not halted,
// both item registers empty.
// Top level of the transcoder; depends on utl_pkg and utl_decode.
module utf8_latin1_transcoder_top import utl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  utl_in_t    in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output utl_out_t   out_item_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  utl_mode_e  mode_q;
  utl_state_t state_q;
  logic       in_vld_q;
  utl_in_t    in_q;
  logic [1:0] out_cnt_q;
  utl_out_t   res0_q;
  utl_out_t   res1_q;
  utl_dec_t   dec;
  logic       out_take;
  logic       out_free;
  logic       s1_take;
  logic       in_take;

  utl_decode u_decode (
    .item_i  (in_q),
    .state_i (state_q),
    .mode_i  (mode_q),
    .dec_o   (dec)
  );

  // Handshake control
  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_item_o  = res0_q;
  assign out_take    = out_valid_o && !out_stall_i;
  assign out_free    = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && out_take);
  assign s1_take     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !s1_take;
  assign in_take     = in_valid_i && !in_stall_o;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDENT;
    end else if (cfg_we_i) begin
      mode_q <= utl_mode_e'(cfg_wdata_i);
    end
  end

  // Input register and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      if (s1_take) begin
        state_q <= dec.state;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (s1_take) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  // Hold the input payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  // Result count: load the decoded count, count down on each taken item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (s1_take) begin
      out_cnt_q <= dec.cnt;
    end else if (out_take) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      res0_q <= dec.res0;
      res1_q <= dec.res1;
    end else if (out_take) begin
      res0_q <= res1_q;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the UTF-8 / Latin-1 transcoder top level.
// Depends on utl_pkg and utf8_latin1_transcoder_top; predicts every result item
// in-line and checks it against the monitored output stream.
`timescale 1ns / 100ps

module tb;
  import utl_pkg::*;

  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 3000;
  localparam int HoldCycles   = 300;
  localparam int LiveTarget   = 450;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  utl_in_t    in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  utl_out_t   out_item_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = 2'd0;

  // Predictor state, mirrors the block
  utl_mode_e cur_mode = MODE_IDENT;
  logic      lead_held = 1'b0;
  logic      lead_c3 = 1'b0;
  logic      dropping = 1'b0;

  utl_in_t   byte_feed_q[$];
  utl_out_t  bytes_due_q[$];

  int pushed_cnt = 0;
  int sent_cnt = 0;
  int live_items = 0;
  int mismatches = 0;
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  utf8_latin1_transcoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result items of one accepted byte and queue them
  function automatic void transcode_byte(input utl_in_t item);
    utl_out_t    res [2];
    int          n;
    logic        err;
    logic [7:0]  b;
    logic [7:0]  lead_val;
    logic [10:0] cp;
    logic        eob;
    b = item.in_byte;
    eob = item.end_of_buffer;
    n = 0;
    err = 1'b0;
    res[0] = '0;
    res[1] = '0;
    if (dropping) begin
      // drop until end of buffer, then flag it
      if (eob) begin
        res[0].status = 1'b1;
        n = 1;
      end
    end else if (lead_held) begin
      // complete the held lead, whatever the mode now is
      lead_val = lead_c3 ? ByteLeadC3 : ByteLeadC2;
      cp = {lead_val[4:0], b[5:0]};
      if ((b & ~ContMask) != ByteHiBit || cp < {3'b000, ByteLatinLo} || cp[10:8] != 3'b000) begin
        err = 1'b1;
      end else begin
        lead_held = 1'b0;
        res[0].out_byte = cp[7:0];
        res[0].has_byte = 1'b1;
        n = 1;
      end
    end else if (cur_mode == MODE_IDENT || !b[7]) begin
      res[0].out_byte = b;
      res[0].has_byte = 1'b1;
      n = 1;
    end else if (cur_mode == MODE_L1_TO_U8) begin
      if (b < ByteLatinLo) begin
        err = 1'b1;
      end else begin
        res[0].out_byte = ByteLead2 | {6'b0, b[7:6]};
        res[0].has_byte = 1'b1;
        res[1].out_byte = ByteHiBit | (b & ContMask);
        res[1].has_byte = 1'b1;
        n = 2;
      end
    end else if (cur_mode == MODE_U8_TO_L1) begin
      if ((b != ByteLeadC2 && b != ByteLeadC3) || eob) begin
        err = 1'b1;
      end else begin
        lead_held = 1'b1;
        lead_c3 = (b == ByteLeadC3);
      end
    end else begin
      err = 1'b1;
    end
    if (err) begin
      lead_held = 1'b0;
      if (!eob) dropping = 1'b1;
      res[0] = '0;
      res[0].status = 1'b1;
      n = 1;
    end
    if (n > 0) begin
      res[n-1].buffer_end = eob;
      res[n-1].last_of_run = 1'b1;
      if (eob) begin
        lead_held = 1'b0;
        dropping = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) bytes_due_q.push_back(res[i]);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Driver: offer queued items, idle a random number of cycles after each
  always @(posedge clk_i) begin
    utl_in_t nxt_item;
    logic    nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      nxt_item = in_item_i;
      if (in_valid_i && !in_stall_o) begin
        if (!(dropping && !in_item_i.end_of_buffer)) live_items++;
        transcode_byte(in_item_i);
        sent_cnt++;
        nxt_valid = 1'b0;
        tx_wait = $urandom_range(0, tx_gap_max);
      end
      if (!nxt_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (byte_feed_q.size() > 0) begin
          nxt_item = byte_feed_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
      in_item_i <= nxt_item;
    end
  end

  // Monitor: check each result item, then stall a random number of cycles
  always @(posedge clk_i) begin
    utl_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (bytes_due_q.size() == 0) begin
          report_mismatch("unexpected item", int'(out_item_o), 0);
        end else begin
          want = bytes_due_q.pop_front();
          check_field("out_byte", int'(out_item_o.out_byte), int'(want.out_byte));
          check_field("has_byte", int'(out_item_o.has_byte), int'(want.has_byte));
          check_field("status", int'(out_item_o.status), int'(want.status));
          check_field("buffer_end", int'(out_item_o.buffer_end), int'(want.buffer_end));
          check_field("last_of_run", int'(out_item_o.last_of_run),
                      int'(want.last_of_run));
        end
        rx_wait = $urandom_range(0, rx_gap_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      // long hold-off on request
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = HoldCycles;
      end
      out_stall_i <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // Count cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic eob);
    utl_in_t item;
    item.in_byte = b;
    item.end_of_buffer = eob;
    byte_feed_q.push_back(item);
    pushed_cnt++;
  endtask

  task automatic set_mode(input utl_mode_e m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  // Hold until every item is sent and answered, then let the pipe settle
  task automatic wait_drain();
    while (sent_cnt != pushed_cnt || bytes_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 19;
    endcase
  endfunction

  // One random buffer: mostly well-formed for the mode, sometimes noise
  task automatic push_buffer(input utl_mode_e m);
    int         chars;
    logic [7:0] b;
    logic       last;
    chars = $urandom_range(1, 8);
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < chars; i++) begin
        last = (i == chars - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
        push_byte(8'($urandom_range(0, 255)), last);
      end
    end else begin
      for (int i = 0; i < chars; i++) begin
        last = (i == chars - 1);
        case (m)
          MODE_U8_TO_L1: begin
            case ($urandom_range(0, 2))
              0: push_byte(8'($urandom_range(0, 127)), last);
              1: begin
                push_byte(ByteLeadC2, 1'b0);
                push_byte(8'($urandom_range(8'ha0, 8'hbf)), last);
              end
              default: begin
                push_byte(ByteLeadC3, 1'b0);
                push_byte(8'($urandom_range(8'h80, 8'hbf)), last);
              end
            endcase
          end
          MODE_L1_TO_U8: begin
            b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                            : 8'($urandom_range(8'ha0, 8'hff));
            push_byte(b, last);
          end
          MODE_RSVD: push_byte(8'($urandom_range(0, 127)), last);
          default:   push_byte(8'($urandom_range(0, 255)), last);
        endcase
      end
    end
  endtask

  initial begin
    int        pick;
    utl_mode_e m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity in the reset mode: byte extremes
    push_byte(8'h00, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b1);
    wait_drain();

    // Latin-1 to UTF-8: expansion, error with end marker, error then drop
    set_mode(MODE_L1_TO_U8);
    push_byte(8'h41, 1'b0);
    push_byte(8'ha0, 1'b0);
    push_byte(8'h9f, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h20, 1'b1);
    wait_drain();

    // UTF-8 to Latin-1: good pairs, bad lead, bad continuation, low code point,
    // truncated lead
    set_mode(MODE_U8_TO_L1);
    push_byte(ByteLeadC3, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(ByteLeadC2, 1'b0);
    push_byte(8'ha0, 1'b0);
    push_byte(8'hc4, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(ByteLeadC2, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(ByteLeadC2, 1'b0);
    push_byte(8'h9f, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(ByteLeadC3, 1'b1);
    // leave a lead held across a mode change
    push_byte(ByteLeadC2, 1'b0);
    wait_drain();
    set_mode(MODE_IDENT);
    push_byte(8'ha5, 1'b1);
    wait_drain();

    // Unused mode
    set_mode(MODE_RSVD);
    push_byte(8'h41, 1'b0);
    push_byte(8'h80, 1'b1);
    wait_drain();

    // Long receiver hold-off while the sender keeps offering expansions
    set_mode(MODE_L1_TO_U8);
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_reqs++;
    for (int i = 0; i < 40; i++) push_byte(8'($urandom_range(8'ha0, 8'hff)), (i == 39));
    wait_drain();

    // Random phases: new mode and idle pattern, a few buffers, then drain
    while (live_items < LiveTarget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) m = MODE_IDENT;
      else if (pick <= 4) m = MODE_L1_TO_U8;
      else if (pick <= 8) m = MODE_U8_TO_L1;
      else m = MODE_RSVD;
      set_mode(m);
      tx_gap_max = pick_gap();
      rx_gap_max = pick_gap();
      repeat ($urandom_range(2, 6)) push_buffer(m);
      wait_drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
